FILE: rtl/core/c3z_pkg.sv
// ----------------------------------------------------------------------------
// c3z_pkg: shared types and constants for the 3x3 zero-padded convolution
// Field widths, register indexes and the tap word passed to the MAC pipeline.
// ----------------------------------------------------------------------------
package c3z_pkg;

  localparam int C3Z_MAX_WIDTH  = 2048;
  localparam int C3Z_MAX_HEIGHT = 2048;
  localparam int C3Z_COEF_BITS  = 16;

  localparam int PIX_W     = 8;
  localparam int DIM_W     = 12;
  localparam int KROW_W    = 48;
  localparam int SLOT_W    = 16;
  localparam int FILT_W    = 28;
  localparam int TAPS      = 9;
  localparam int CFG_IDX_W = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_TOP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_MIDDLE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_BOTTOM = 3'd4;

  localparam logic [DIM_W-1:0]  RST_IMAGE_WIDTH   = 12'd640;
  localparam logic [DIM_W-1:0]  RST_IMAGE_HEIGHT  = 12'd480;
  localparam logic [KROW_W-1:0] RST_KERNEL_TOP    = 48'h0000_0000_0000;
  localparam logic [KROW_W-1:0] RST_KERNEL_MIDDLE = 48'h0000_0100_0000;
  localparam logic [KROW_W-1:0] RST_KERNEL_BOTTOM = 48'h0000_0000_0000;

  typedef logic [TAPS-1:0][PIX_W-1:0] c3z_view_t;

  // one masked 3x3 neighbourhood plus its end-of-frame flag
  typedef struct packed {
    c3z_view_t px;
    logic      last;
  } c3z_tap_t;

  // kernel rows: top, middle, bottom
  typedef logic [2:0][KROW_W-1:0] c3z_kern_t;

endpackage

FILE: rtl/core/c3z_mac.sv
// ----------------------------------------------------------------------------
// c3z_mac: multiply-accumulate pipeline for one 3x3 neighbourhood
// Nine products, three row sums, then the final sum into the output register.
// ----------------------------------------------------------------------------
module c3z_mac
  import c3z_pkg::*;
#(
  parameter int COEF_BITS = C3Z_COEF_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  c3z_kern_t                kern,
  input  logic                     tap_valid,
  output logic                     tap_stall,
  input  c3z_tap_t                 tap,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [FILT_W-1:0] out_filtered,
  output logic                     out_end_of_frame
);

  localparam int PROD_W = COEF_BITS + PIX_W + 1;
  localparam int RSUM_W = PROD_W + 2;
  localparam int SUM_W  = PROD_W + 4;

  logic                            p_v_r;
  logic                            p_last_r;
  logic signed [PROD_W-1:0]        prod_r [TAPS];
  logic signed [PROD_W-1:0]        prod_nxt [TAPS];
  logic                            s_v_r;
  logic                            s_last_r;
  logic signed [RSUM_W-1:0]        rsum_r [3];
  logic signed [RSUM_W-1:0]        rsum_nxt [3];
  logic signed [SUM_W-1:0]         sum_nxt;
  logic                            o_v_r;
  logic                            o_last_r;
  logic signed [FILT_W-1:0]        o_filt_r;
  logic                            o_rdy;
  logic                            s_rdy;
  logic                            p_rdy;

  assign o_rdy     = !o_v_r || !out_stall;
  assign s_rdy     = !s_v_r || o_rdy;
  assign p_rdy     = !p_v_r || s_rdy;
  assign tap_stall = !p_rdy;

  always_comb begin
    logic signed [PIX_W:0]       pxs;
    logic signed [COEF_BITS-1:0] cf;
    for (int i = 0; i < TAPS; i++) begin
      pxs = signed'({1'b0, tap.px[i]});
      cf  = signed'(kern[i / 3][SLOT_W * (i % 3) +: COEF_BITS]);
      prod_nxt[i] = PROD_W'(pxs) * PROD_W'(cf);
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      rsum_nxt[r] = RSUM_W'(prod_r[3 * r]) + RSUM_W'(prod_r[3 * r + 1])
                  + RSUM_W'(prod_r[3 * r + 2]);
    end
    sum_nxt = SUM_W'(rsum_r[0]) + SUM_W'(rsum_r[1]) + SUM_W'(rsum_r[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
      s_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      if (p_rdy) p_v_r <= tap_valid;
      if (s_rdy) s_v_r <= p_v_r;
      if (o_rdy) o_v_r <= s_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (p_rdy && tap_valid) begin
      prod_r   <= prod_nxt;
      p_last_r <= tap.last;
    end
    if (s_rdy && p_v_r) begin
      rsum_r   <= rsum_nxt;
      s_last_r <= p_last_r;
    end
    if (o_rdy && s_v_r) begin
      o_filt_r <= FILT_W'(sum_nxt);
      o_last_r <= s_last_r;
    end
  end

  assign out_valid        = o_v_r;
  assign out_filtered     = o_filt_r;
  assign out_end_of_frame = o_last_r;

endmodule

FILE: rtl/core/conv3x3_zero_padded.sv
// ----------------------------------------------------------------------------
// conv3x3_zero_padded: 3x3 convolution over a raster pixel stream
//
//   port group | handshake            | word
//   -----------+----------------------+----------------------------------
//   in_        | in_valid / in_stall  | kind, pixel
//   out_       | out_valid / out_stall| filtered (s28, Q.8), end_of_frame
//   cfg_       | cfg_valid / cfg_ready| cfg_index, cfg_data (48 bit)
//
// One word is taken every clock while in_stall is low. The line stores are
// read ahead at the next column, so the window update, edge masking and line
// write fit in the accept cycle. A result then passes the tap, product,
// row-sum and sum registers; the word that completes its neighbourhood
// comes one row plus one pixel after the pixel itself.
// Reset clears counters, window and pipeline; the line stores are not cleared.
// A stalled output backs up through the pipeline bubbles into in_stall.
// ----------------------------------------------------------------------------
module conv3x3_zero_padded
  import c3z_pkg::*;
#(
  parameter int MAX_WIDTH  = C3Z_MAX_WIDTH,
  parameter int MAX_HEIGHT = C3Z_MAX_HEIGHT,
  parameter int COEF_BITS  = C3Z_COEF_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_kind,
  input  logic [PIX_W-1:0]         in_pixel,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [FILT_W-1:0] out_filtered,
  output logic                     out_end_of_frame,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [KROW_W-1:0]        cfg_data
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT + 2);
  localparam int WMAX_W = $clog2(MAX_WIDTH + 1);
  localparam int CW     = ((DIM_W > WMAX_W) ? DIM_W : WMAX_W) + 1;
  localparam int RW     = ((DIM_W > ROW_W) ? DIM_W : ROW_W) + 1;

  // configuration
  logic [DIM_W-1:0]  img_w_r;
  logic [DIM_W-1:0]  img_h_r;
  c3z_kern_t         kern_r;

  // frame state
  logic [COL_W-1:0]  in_col_r;
  logic [ROW_W-1:0]  in_row_r;
  logic [COL_W-1:0]  out_col_r;
  logic [ROW_W-1:0]  out_row_r;
  c3z_view_t         win_r;

  // line stores with prefetched read data and same-address bypass
  logic [PIX_W-1:0]  lb1_mem_r [MAX_WIDTH];
  logic [PIX_W-1:0]  lb2_mem_r [MAX_WIDTH];
  logic [PIX_W-1:0]  lb1_rd_r;
  logic [PIX_W-1:0]  lb2_rd_r;
  logic              byp_r;
  logic [PIX_W-1:0]  byp1_r;
  logic [PIX_W-1:0]  byp2_r;

  // tap register toward the MAC
  logic              s1_v_r;
  c3z_tap_t          s1_tap_r;

  logic              acc;
  logic              s1_rdy;
  logic              mac_stall;
  logic [CW-1:0]     w_raw;
  logic [CW-1:0]     w_eff;
  logic [RW-1:0]     h_raw;
  logic [RW-1:0]     h_eff;
  logic              in_col_end;
  logic              past_h;
  logic              emit;
  logic              wrap;
  logic              out_col_end;
  logic              out_row_end;
  logic              last;
  logic              frame_clr;
  logic [PIX_W-1:0]  px_eff;
  logic [PIX_W-1:0]  top;
  logic [PIX_W-1:0]  mid;
  c3z_view_t         win_nxt;
  c3z_view_t         view;
  c3z_tap_t          tap_nxt;
  logic [COL_W-1:0]  in_col_nxt;
  logic [ROW_W-1:0]  in_row_nxt;
  logic [COL_W-1:0]  out_col_nxt;
  logic [ROW_W-1:0]  out_row_nxt;
  logic [COL_W-1:0]  rd_addr;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= RST_IMAGE_WIDTH;
      img_h_r <= RST_IMAGE_HEIGHT;
      kern_r  <= {RST_KERNEL_BOTTOM, RST_KERNEL_MIDDLE, RST_KERNEL_TOP};
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:   img_w_r   <= cfg_data[DIM_W-1:0];
        CFG_IMAGE_HEIGHT:  img_h_r   <= cfg_data[DIM_W-1:0];
        CFG_KERNEL_TOP:    kern_r[0] <= cfg_data;
        CFG_KERNEL_MIDDLE: kern_r[1] <= cfg_data;
        CFG_KERNEL_BOTTOM: kern_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s1_rdy   = !s1_v_r || !mac_stall;
  assign in_stall = !rst_n || !s1_rdy;
  assign acc      = in_valid && !in_stall;

  // effective frame size: zero means one, width clamps at the store depth, height at MAX_HEIGHT
  always_comb begin
    w_raw = CW'(img_w_r);
    h_raw = RW'(img_h_r);
    if (img_w_r == '0)               w_eff = CW'(1);
    else if (w_raw > CW'(MAX_WIDTH)) w_eff = CW'(MAX_WIDTH);
    else                             w_eff = w_raw;
    if (img_h_r == '0)                h_eff = RW'(1);
    else if (h_raw > RW'(MAX_HEIGHT)) h_eff = RW'(MAX_HEIGHT);
    else                              h_eff = h_raw;
  end

  always_comb begin
    logic keep;
    in_col_end  = (CW'(in_col_r) + CW'(1)) >= w_eff;
    past_h      = RW'(in_row_r) >= h_eff;
    emit        = (in_row_r >= ROW_W'(2)) || ((in_row_r == ROW_W'(1)) && (in_col_r != '0));
    wrap        = (in_col_r == '0);
    out_col_end = (CW'(out_col_r) + CW'(1)) >= w_eff;
    out_row_end = (RW'(out_row_r) + RW'(1)) >= h_eff;
    last        = out_col_end && out_row_end;
    frame_clr   = emit && last;

    // drain ticks and pixels past the last row enter as zero
    px_eff = (in_kind || past_h) ? '0 : in_pixel;
    top    = byp_r ? byp2_r : lb2_rd_r;
    mid    = byp_r ? byp1_r : lb1_rd_r;

    for (int r = 0; r < 3; r++) begin
      win_nxt[3 * r]     = win_r[3 * r + 1];
      win_nxt[3 * r + 1] = win_r[3 * r + 2];
    end
    win_nxt[2] = top;
    win_nxt[5] = mid;
    win_nxt[8] = px_eff;

    // first column of a row closes the previous row's last result
    for (int r = 0; r < 3; r++) begin
      if (wrap) begin
        view[3 * r]     = win_r[3 * r + 1];
        view[3 * r + 1] = win_r[3 * r + 2];
        view[3 * r + 2] = '0;
      end else begin
        view[3 * r]     = win_nxt[3 * r];
        view[3 * r + 1] = win_nxt[3 * r + 1];
        view[3 * r + 2] = win_nxt[3 * r + 2];
      end
    end

    // frame-edge masking
    for (int i = 0; i < TAPS; i++) begin
      keep = 1'b1;
      if (i < 3 && out_row_r == '0) keep = 1'b0;
      if (i >= 6 && out_row_end)    keep = 1'b0;
      if (i % 3 == 0 && out_col_r == '0) keep = 1'b0;
      if (i % 3 == 2 && out_col_end)     keep = 1'b0;
      tap_nxt.px[i] = keep ? view[i] : '0;
    end
    tap_nxt.last = last;

    if (in_col_end) begin
      in_col_nxt = '0;
      in_row_nxt = in_row_r + ROW_W'(1);
    end else begin
      in_col_nxt = in_col_r + COL_W'(1);
      in_row_nxt = in_row_r;
    end
    if (!emit) begin
      out_col_nxt = out_col_r;
      out_row_nxt = out_row_r;
    end else if (out_col_end) begin
      out_col_nxt = '0;
      out_row_nxt = out_row_r + ROW_W'(1);
    end else begin
      out_col_nxt = out_col_r + COL_W'(1);
      out_row_nxt = out_row_r;
    end
    if (frame_clr) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end

    if (!rst_n)   rd_addr = '0;
    else if (acc) rd_addr = in_col_nxt;
    else          rd_addr = in_col_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      win_r     <= '0;
      byp_r     <= 1'b0;
      s1_v_r    <= 1'b0;
    end else begin
      if (acc) begin
        in_col_r  <= in_col_nxt;
        in_row_r  <= in_row_nxt;
        out_col_r <= out_col_nxt;
        out_row_r <= out_row_nxt;
        win_r     <= frame_clr ? '0 : win_nxt;
      end
      // next read hits the column just written when the row is one wide or a frame ends at column zero
      byp_r <= acc && (in_col_nxt == in_col_r);
      if (s1_rdy) s1_v_r <= acc && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      lb1_mem_r[in_col_r] <= px_eff;
      lb2_mem_r[in_col_r] <= mid;
    end
    lb1_rd_r <= lb1_mem_r[rd_addr];
    lb2_rd_r <= lb2_mem_r[rd_addr];
    byp1_r   <= px_eff;
    byp2_r   <= mid;
  end

  always_ff @(posedge clk) begin
    if (acc && emit) s1_tap_r <= tap_nxt;
  end

  c3z_mac #(
    .COEF_BITS (COEF_BITS)
  ) u_mac (
    .clk              (clk),
    .rst_n            (rst_n),
    .kern             (kern_r),
    .tap_valid        (s1_v_r),
    .tap_stall        (mac_stall),
    .tap              (s1_tap_r),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_filtered     (out_filtered),
    .out_end_of_frame (out_end_of_frame)
  );

endmodule

FILE: test/conv3x3_zero_padded_checker.sv
// ----------------------------------------------------------------------------
// conv3x3_zero_padded_checker: result predictor and scoreboard
// Follows configuration writes and accepted input words and works out the
// expected filtered sum for every pixel. Each accepted output word is compared
// with the oldest expected one. Failures and the number of results still due
// go back to the testbench top.
// ----------------------------------------------------------------------------
module conv3x3_zero_padded_checker
  import c3z_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic                     in_kind,
  input  logic [PIX_W-1:0]         in_pixel,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic signed [FILT_W-1:0] out_filtered,
  input  logic                     out_end_of_frame,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [KROW_W-1:0]        cfg_data,
  output int                       mismatches,
  output int                       pending
);

  typedef struct packed {
    logic signed [FILT_W-1:0] filtered;
    logic                     end_of_frame;
  } pixel_sum_t;

  pixel_sum_t       sums_q[$];
  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;
  logic [KROW_W-1:0] kernel_reg [3];
  logic [PIX_W-1:0] line_up1 [C3Z_MAX_WIDTH];
  logic [PIX_W-1:0] line_up2 [C3Z_MAX_WIDTH];
  logic [PIX_W-1:0] nbhd [TAPS];
  int unsigned      px_row;
  int unsigned      px_col;
  int unsigned      sum_row;
  int unsigned      sum_col;
  int               errors = 0;
  int               checked = 0;

  function automatic int unsigned clamp_size(logic [DIM_W-1:0] v, int unsigned lim);
    if (v == 0) return 1;
    return (v > lim) ? lim : int'(v);
  endfunction

  function automatic logic signed [C3Z_COEF_BITS-1:0] weight(logic [KROW_W-1:0] krow,
                                                              int slot);
    return krow[slot*SLOT_W +: C3Z_COEF_BITS];
  endfunction

  task automatic restart_frame();
    foreach (nbhd[i]) nbhd[i] = '0;
    px_row  = 0;
    px_col  = 0;
    sum_row = 0;
    sum_col = 0;
  endtask

  task automatic convolve_word(input logic kind, input logic [PIX_W-1:0] px_in);
    int unsigned            w;
    int unsigned            h;
    int unsigned            col;
    logic [PIX_W-1:0]       px;
    logic [PIX_W-1:0]       up2;
    logic [PIX_W-1:0]       up1;
    logic [PIX_W-1:0]       view [TAPS];
    logic                   wrap;
    logic                   emit;
    longint                 acc;
    pixel_sum_t             res;
    w    = clamp_size(width_reg, C3Z_MAX_WIDTH);
    h    = clamp_size(height_reg, C3Z_MAX_HEIGHT);
    // drain ticks and anything past the last row feed zeros
    px   = (kind || px_row >= h) ? '0 : px_in;
    col  = px_col % C3Z_MAX_WIDTH;
    wrap = (px_col == 0);
    emit = (px_row >= 2) || (px_row == 1 && px_col >= 1);
    up2  = line_up2[col];
    up1  = line_up1[col];
    // a row wrap finishes the previous row's last column: right taps are outside
    if (wrap) begin
      for (int r = 0; r < 3; r++) begin
        view[r*3]   = nbhd[r*3+1];
        view[r*3+1] = nbhd[r*3+2];
        view[r*3+2] = '0;
      end
    end
    for (int r = 0; r < 3; r++) begin
      nbhd[r*3]   = nbhd[r*3+1];
      nbhd[r*3+1] = nbhd[r*3+2];
    end
    nbhd[2] = up2;
    nbhd[5] = up1;
    nbhd[8] = px;
    if (!wrap) view = nbhd;
    line_up2[col] = up1;
    line_up1[col] = px;
    if (px_col + 1 >= w) begin
      px_col = 0;
      px_row++;
    end else begin
      px_col++;
    end
    if (emit) begin
      acc = 0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          if (!((r == 0 && sum_row == 0) || (r == 2 && sum_row + 1 >= h) ||
                (c == 0 && sum_col == 0) || (c == 2 && sum_col + 1 >= w)))
            acc += longint'(view[r*3+c]) * longint'(weight(kernel_reg[r], c));
        end
      end
      res.filtered     = acc[FILT_W-1:0];
      res.end_of_frame = (sum_row + 1 >= h) && (sum_col + 1 >= w);
      sums_q.insert(sums_q.size(), res);
      if (res.end_of_frame) begin
        restart_frame();
      end else if (sum_col + 1 >= w) begin
        sum_col = 0;
        sum_row++;
      end else begin
        sum_col++;
      end
    end
  endtask

  always @(posedge clk) begin
    pixel_sum_t exp_sum;
    if (!rst_n) begin
      width_reg     = RST_IMAGE_WIDTH;
      height_reg    = RST_IMAGE_HEIGHT;
      kernel_reg[0] = RST_KERNEL_TOP;
      kernel_reg[1] = RST_KERNEL_MIDDLE;
      kernel_reg[2] = RST_KERNEL_BOTTOM;
      restart_frame();
      sums_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_IMAGE_WIDTH:   width_reg = cfg_data[DIM_W-1:0];
          CFG_IMAGE_HEIGHT:  height_reg = cfg_data[DIM_W-1:0];
          CFG_KERNEL_TOP:    kernel_reg[0] = cfg_data;
          CFG_KERNEL_MIDDLE: kernel_reg[1] = cfg_data;
          CFG_KERNEL_BOTTOM: kernel_reg[2] = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) convolve_word(in_kind, in_pixel);
      if (out_valid && !out_stall) begin
        if (sums_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("error: result with nothing due, filtered %0d end_of_frame %0b",
                     out_filtered, out_end_of_frame);
        end else begin
          exp_sum = sums_q.pop_front();
          if (out_filtered !== exp_sum.filtered ||
              out_end_of_frame !== exp_sum.end_of_frame) begin
            errors++;
            if (errors <= 10)
              $display("error: result %0d filtered exp %0d got %0d, eof exp %0b got %0b",
                       checked, exp_sum.filtered, out_filtered,
                       exp_sum.end_of_frame, out_end_of_frame);
          end
        end
        checked++;
      end
    end
    mismatches <= errors;
    pending    <= sums_q.size();
  end

endmodule

FILE: test/conv3x3_zero_padded_test.sv
// ----------------------------------------------------------------------------
// conv3x3_zero_padded_test: testbench top for the 3x3 convolution
// Streams whole frames through the block: a few directed frames with extreme
// kernels and pixels, a size change in the middle of a frame, clamped sizes,
// then random frames with random kernels, drain ticks and random pacing on
// both sides. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module conv3x3_zero_padded_test;
  import c3z_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_WORDS = 800;
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_HOLD    = 400;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  localparam logic [SLOT_W-1:0] COEF_MOST_NEG = 16'h8000;
  localparam logic [SLOT_W-1:0] COEF_MOST_POS = 16'h7FFF;

  typedef enum {PX_RANDOM, PX_BRIGHT} px_mode_t;

  logic                     clk       = 1'b0;
  logic                     rst_n     = 1'b0;
  logic                     in_valid  = 1'b0;
  logic                     in_kind   = 1'b0;
  logic [PIX_W-1:0]         in_pixel  = '0;
  logic                     cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [KROW_W-1:0]        cfg_data  = '0;
  logic                     rx_stall  = 1'b0;
  logic                     hold_out  = 1'b0;
  logic                     hold_go   = 1'b0;
  logic                     out_stall;
  logic                     in_stall;
  logic                     out_valid;
  logic signed [FILT_W-1:0] out_filtered;
  logic                     out_end_of_frame;
  logic                     cfg_ready;
  int                       mismatches;
  int                       pending;
  int                       cycle_count = 0;
  int                       sent = 0;
  bit                       tx_calm = 1'b0;

  assign out_stall = rx_stall | hold_out;

  conv3x3_zero_padded u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_pixel         (in_pixel),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_filtered     (out_filtered),
    .out_end_of_frame (out_end_of_frame),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  conv3x3_zero_padded_checker u_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_pixel         (in_pixel),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_filtered     (out_filtered),
    .out_end_of_frame (out_end_of_frame),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatches       (mismatches),
    .pending          (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int unsigned dim_of(logic [DIM_W-1:0] v);
    if (v == 0) return 1;
    return (v > C3Z_MAX_WIDTH) ? C3Z_MAX_WIDTH : int'(v);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [KROW_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // size registers carry junk above bit 11
  task automatic write_size(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] v);
    write_reg(idx, {$urandom(), 4'($urandom()), v});
  endtask

  task automatic put_word(input logic kind, input logic [PIX_W-1:0] px);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 5);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_pixel <= px;
    do @(posedge clk); while (in_stall);
    sent++;
    if (sent % 60 == 0) tx_calm = ($urandom_range(0, 3) == 0);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one whole frame: pixels, then one row plus one word to flush the tail
  task automatic run_frame(input logic [DIM_W-1:0] w_cfg, input logic [DIM_W-1:0] h_cfg,
                           input px_mode_t mode, input int drain_pct);
    int unsigned      body;
    int unsigned      w;
    logic [PIX_W-1:0] px;
    write_size(CFG_IMAGE_WIDTH, w_cfg);
    write_size(CFG_IMAGE_HEIGHT, h_cfg);
    w    = dim_of(w_cfg);
    body = w * dim_of(h_cfg);
    for (int unsigned i = 0; i < body + w + 1; i++) begin
      px = (mode == PX_BRIGHT) ? '1 : PIX_W'($urandom());
      if (i < body)
        put_word(($urandom_range(0, 99) < drain_pct) ? KIND_DRAIN : KIND_PIXEL, px);
      else
        put_word($urandom_range(0, 1) ? KIND_DRAIN : KIND_PIXEL, px);
    end
    settle();
  endtask

  initial begin
    int  taken;
    bit  rx_calm;
    taken   = 0;
    rx_calm = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      repeat (rx_calm ? 0 : $urandom_range(0, 5)) begin
        rx_stall <= 1'b1;
        @(posedge clk);
      end
      rx_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      taken++;
      if (taken % 50 == 0) rx_calm = ($urandom_range(0, 3) == 0);
    end
  end

  // one long output hold so the pipeline backs up into in_stall
  initial begin
    while (!hold_go) @(posedge clk);
    hold_out <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    hold_out <= 1'b0;
  end

  initial begin
    logic [KROW_W-1:0] krow;
    int                rand_start;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // indexes past the kernel rows hit no register
    for (int i = CFG_KERNEL_BOTTOM + 1; i < 2**CFG_IDX_W; i++)
      write_reg(CFG_IDX_W'(i), {$urandom(), 16'($urandom())});

    // most negative sum, then most positive
    write_reg(CFG_KERNEL_TOP, {3{COEF_MOST_NEG}});
    write_reg(CFG_KERNEL_MIDDLE, {3{COEF_MOST_NEG}});
    write_reg(CFG_KERNEL_BOTTOM, {3{COEF_MOST_NEG}});
    run_frame(DIM_W'(3), DIM_W'(3), PX_BRIGHT, 0);
    write_reg(CFG_KERNEL_TOP, {3{COEF_MOST_POS}});
    write_reg(CFG_KERNEL_MIDDLE, {3{COEF_MOST_POS}});
    write_reg(CFG_KERNEL_BOTTOM, {3{COEF_MOST_POS}});
    run_frame(DIM_W'(3), DIM_W'(3), PX_BRIGHT, 0);

    // shrink the frame after three rows; one drain tick in the middle,
    // and the last row's words are pixels that land past the new height
    write_reg(CFG_KERNEL_TOP, {$urandom(), 16'($urandom())});
    write_reg(CFG_KERNEL_BOTTOM, {COEF_MOST_NEG, COEF_MOST_POS, 16'($urandom())});
    write_reg(CFG_KERNEL_MIDDLE, RST_KERNEL_MIDDLE);
    write_size(CFG_IMAGE_WIDTH, DIM_W'(6));
    write_size(CFG_IMAGE_HEIGHT, DIM_W'(5));
    for (int i = 0; i < 18; i++)
      put_word((i == 9) ? KIND_DRAIN : KIND_PIXEL, (i == 0) ? '0 : PIX_W'($urandom()));
    settle();
    write_size(CFG_IMAGE_WIDTH, DIM_W'(4));
    write_size(CFG_IMAGE_HEIGHT, DIM_W'(4));
    for (int i = 0; i < 9; i++) put_word(KIND_PIXEL, PIX_W'($urandom()));
    settle();

    // zero dimensions clamp to one
    run_frame('0, '0, PX_RANDOM, 8);

    // oversize width clamps to the store depth; a narrower width then wraps
    // the row early and the frame ends after two rows
    write_size(CFG_IMAGE_WIDTH, '1);
    write_size(CFG_IMAGE_HEIGHT, DIM_W'(2));
    for (int i = 0; i < 30; i++) put_word(KIND_PIXEL, PIX_W'($urandom()));
    settle();
    write_size(CFG_IMAGE_WIDTH, DIM_W'(5));
    for (int i = 0; i < 12; i++) put_word(KIND_PIXEL, PIX_W'($urandom()));
    settle();

    // oversize height on a one-wide frame, then a shrink ends it
    write_size(CFG_IMAGE_WIDTH, DIM_W'(1));
    write_size(CFG_IMAGE_HEIGHT, '1);
    for (int i = 0; i < 10; i++) put_word(KIND_PIXEL, PIX_W'($urandom()));
    settle();
    write_size(CFG_IMAGE_HEIGHT, DIM_W'(3));
    put_word(KIND_PIXEL, PIX_W'($urandom()));
    settle();

    rand_start = sent;
    hold_go <= 1'b1;
    run_frame(DIM_W'(20), DIM_W'(6), PX_RANDOM, 8);
    while (sent - rand_start < RANDOM_WORDS) begin
      if ($urandom_range(0, 9) == 0)
        write_reg(CFG_IDX_W'($urandom_range(CFG_KERNEL_BOTTOM + 1, 2**CFG_IDX_W - 1)),
                  {$urandom(), 16'($urandom())});
      for (int r = 0; r < 3; r++) begin
        if ($urandom_range(0, 1)) begin
          for (int s = 0; s < 3; s++) begin
            case ($urandom_range(0, 5))
              0:       krow[s*SLOT_W +: SLOT_W] = COEF_MOST_NEG;
              1:       krow[s*SLOT_W +: SLOT_W] = COEF_MOST_POS;
              default: krow[s*SLOT_W +: SLOT_W] = SLOT_W'($urandom());
            endcase
          end
          write_reg(CFG_IDX_W'(CFG_KERNEL_TOP + r), krow);
        end
      end
      run_frame(($urandom_range(0, 9) == 0) ? DIM_W'($urandom_range(17, 64))
                                            : DIM_W'($urandom_range(1, 16)),
                DIM_W'($urandom_range(1, 8)), PX_RANDOM, 8);
    end

    settle();
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

FILE: conv3x3_zero_padded.f
rtl/core/c3z_pkg.sv
rtl/core/c3z_mac.sv
rtl/core/conv3x3_zero_padded.sv
test/conv3x3_zero_padded_checker.sv
test/conv3x3_zero_padded_test.sv
